// ===== rtl/core/sdpfc_pkg.sv =====
// Shared types, constants and register codes for the pulse frame capture block.
package sdpfc_pkg;

	localparam int BUF_DEPTH   = 256;
	localparam int MEM_DEPTH   = BUF_DEPTH + 1;
	localparam int DUR_W       = 32;
	localparam int LEN_W       = 9;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int MEM_WORDS   = 2 * (1 << ADDR_W);
	localparam int HEAD_LEN    = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;

	localparam logic [DUR_W-1:0] SYNC_MIN_RST      = 32'd2500;
	localparam logic [DUR_W-1:0] SYNC_MAX_RST      = 32'd100000;
	localparam logic [DUR_W-1:0] GLITCH_LIMIT_RST  = 32'd60;
	localparam logic [DUR_W-1:0] SYNC_CAP_RST      = 32'd10000;
	localparam logic [DUR_W-1:0] SYNC_FALLBACK_RST = 32'd17000;
	localparam logic [LEN_W-1:0] MIN_FRAME_LEN_RST = 9'd20;

	typedef enum logic [1:0] {
		KIND_PULSE   = 2'd0,
		KIND_READ    = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SYNC_MIN      = 3'd0,
		CFG_SYNC_MAX      = 3'd1,
		CFG_GLITCH_LIMIT  = 3'd2,
		CFG_SYNC_CAP      = 3'd3,
		CFG_SYNC_FALLBACK = 3'd4,
		CFG_MIN_FRAME_LEN = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [DUR_W-1:0] sync_min;
		logic [DUR_W-1:0] sync_max;
		logic [DUR_W-1:0] glitch_limit;
		logic [DUR_W-1:0] sync_cap;
		logic [DUR_W-1:0] sync_fallback;
		logic [LEN_W-1:0] min_frame_length;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [DUR_W-1:0]  dur;
		logic [DUR_W+3:0]  dur15;
		logic [DUR_W+2:0]  dur5;
		logic              in_window;
		logic              glitch;
		logic [DUR_W-1:0]  ref_val;
		logic [LEN_W-1:0]  idx;
	} item_t;

	typedef struct packed {
		logic             frame_pending;
		logic [LEN_W-1:0] frame_length;
		logic             frame_committed;
		logic             frame_dropped;
		logic [LEN_W-1:0] capture_length;
	} result_t;

endpackage

// ===== rtl/core/sdpfc_front.sv =====
// Front end: accepts input beats and classifies each against the configuration.
module sdpfc_front (
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  kind,
	input  logic [sdpfc_pkg::DUR_W-1:0] duration,
	input  logic [sdpfc_pkg::LEN_W-1:0] read_index,
	input  sdpfc_pkg::cfg_t             cfg,
	input  logic                        queue_full,
	output logic                        push,
	output sdpfc_pkg::item_t            item
);

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		item.kind      = sdpfc_pkg::kind_t'(kind);
		item.dur       = duration;
		item.dur15     = (sdpfc_pkg::DUR_W+4)'(duration) * (sdpfc_pkg::DUR_W+4)'(15);
		item.dur5      = (sdpfc_pkg::DUR_W+3)'(duration) * (sdpfc_pkg::DUR_W+3)'(5);
		item.in_window = (duration > cfg.sync_min) && (duration < cfg.sync_max);
		item.glitch    = duration < cfg.glitch_limit;
		item.ref_val   = (duration < cfg.sync_cap) ? duration : cfg.sync_fallback;
		item.idx       = read_index;
	end

endmodule

// ===== rtl/core/sdpfc_queue.sv =====
// Short queue of classified beats between the front and back ends.
module sdpfc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sdpfc_pkg::item_t push_item,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output sdpfc_pkg::item_t head_item
);

	sdpfc_pkg::item_t                entry_q [sdpfc_pkg::QUEUE_DEPTH];
	logic [sdpfc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [sdpfc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [sdpfc_pkg::QCNT_W-1:0]    count_q;

	assign full       = count_q == sdpfc_pkg::QCNT_W'(sdpfc_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sdpfc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sdpfc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + sdpfc_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - sdpfc_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/sdpfc_back.sv =====
// Back end: capture state, double frame buffer and registered result beat.
module sdpfc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  sdpfc_pkg::item_t            it,
	input  logic [sdpfc_pkg::LEN_W-1:0] min_frame_length,
	output logic                        pop,
	input  logic                        out_stall,
	output logic                        out_valid,
	output sdpfc_pkg::result_t          res,
	output logic [sdpfc_pkg::DUR_W-1:0] read_data
);

	localparam int DW = sdpfc_pkg::DUR_W;
	localparam int LW = sdpfc_pkg::LEN_W;
	localparam int AW = sdpfc_pkg::ADDR_W;

	logic [DW-1:0]  buf_mem_q [sdpfc_pkg::MEM_WORDS];
	logic [DW-1:0]  head0_q [2];
	logic [DW-1:0]  head1_q [2];
	logic [DW-1:0]  prev_q;
	logic [DW-1:0]  sref_q;
	logic [LW-1:0]  cnt_q;
	logic [LW-1:0]  pend_q;
	logic           sel_q;

	logic           out_valid_q;
	sdpfc_pkg::result_t res_q;
	logic [DW-1:0]  rd_mem_q;
	logic [DW-1:0]  rd_head_q;
	logic           rd_hit_q;
	logic           rd_head_sel_q;

	logic           advance;
	logic [DW-1:0]  prev_n;
	logic [DW-1:0]  sref_n;
	logic [LW-1:0]  cnt_n;
	logic [LW-1:0]  pend_n;
	logic           sel_n;
	logic           mem_we;
	logic           head_we;
	logic           committed;
	logic           dropped;
	logic           end_hit;
	logic [LW-1:0]  cnt_inc;
	logic           rd_hit;
	logic           rd_head;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = head_valid && advance;
	assign cnt_inc = cnt_q + LW'(1);
	assign end_hit = ({4'd0, sref_q} <= it.dur15) && (it.dur5 > {1'b0, sref_q, 2'b00});
	assign rd_hit  = (it.kind == sdpfc_pkg::KIND_READ) && (it.idx < pend_q);
	assign rd_head = it.idx < LW'(sdpfc_pkg::HEAD_LEN);

	always_comb begin
		prev_n    = prev_q;
		sref_n    = sref_q;
		cnt_n     = cnt_q;
		pend_n    = pend_q;
		sel_n     = sel_q;
		mem_we    = 1'b0;
		head_we   = 1'b0;
		committed = 1'b0;
		dropped   = 1'b0;
		case (it.kind)
			sdpfc_pkg::KIND_PULSE: begin
				prev_n = it.dur;
				if ({4'd0, sref_q} > it.dur15) begin
					sref_n = it.dur15[DW-1:0];
				end
				if (cnt_q == '0 && it.in_window) begin
					cnt_n   = LW'(sdpfc_pkg::HEAD_LEN);
					head_we = 1'b1;
					sref_n  = it.ref_val;
				end else if (it.glitch) begin
					cnt_n = '0;
				end else if (end_hit && cnt_q != '0) begin
					sref_n  = it.ref_val;
					mem_we  = 1'b1;
					head_we = 1'b1;
					cnt_n   = LW'(sdpfc_pkg::HEAD_LEN);
					if (pend_q != '0 || cnt_inc < min_frame_length) begin
						dropped = 1'b1;
					end else begin
						pend_n    = cnt_inc;
						sel_n     = ~sel_q;
						committed = 1'b1;
					end
				end else if (cnt_q >= LW'(sdpfc_pkg::BUF_DEPTH)) begin
					pend_n    = cnt_q;
					sel_n     = ~sel_q;
					cnt_n     = '0;
					committed = 1'b1;
				end else if (cnt_q != '0) begin
					mem_we = 1'b1;
					cnt_n  = cnt_inc;
				end
			end
			sdpfc_pkg::KIND_RELEASE: begin
				pend_n = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (mem_we) begin
				buf_mem_q[{sel_q, cnt_q[AW-1:0]}] <= it.dur;
			end
			if (head_we) begin
				head0_q[sel_n] <= prev_q;
				head1_q[sel_n] <= it.dur;
			end
			rd_mem_q      <= buf_mem_q[{~sel_q, it.idx[AW-1:0]}];
			rd_head_q     <= it.idx[0] ? head1_q[~sel_q] : head0_q[~sel_q];
			rd_head_sel_q <= rd_head;
		end
		if (advance) begin
			res_q.frame_pending   <= pend_n != '0;
			res_q.frame_length    <= pend_n;
			res_q.frame_committed <= committed;
			res_q.frame_dropped   <= dropped;
			res_q.capture_length  <= cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			sref_q      <= '0;
			cnt_q       <= '0;
			pend_q      <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
			rd_hit_q    <= 1'b0;
		end else begin
			if (pop) begin
				prev_q <= prev_n;
				sref_q <= sref_n;
				cnt_q  <= cnt_n;
				pend_q <= pend_n;
				sel_q  <= sel_n;
			end
			if (advance) begin
				out_valid_q <= pop;
				rd_hit_q    <= pop && rd_hit;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;
	assign read_data = !rd_hit_q ? '0 : (rd_head_sel_q ? rd_head_q : rd_mem_q);

endmodule

// ===== rtl/core/sync_delimited_pulse_frame_capture_top.sv =====
// Top level of the sync-delimited pulse frame capture block.
// Input channel (in_valid/in_stall) takes one beat per cycle unless stalled; kind
// selects a pulse duration, a read of the committed frame at read_index, or a
// release of that frame. Every input beat yields exactly one result beat on the
// output channel (out_valid/out_stall) with frame status, read data and capture
// length. An accepted beat is registered in the queue and then in the result
// register; throughput is one beat per cycle while out_stall is low, set by the
// combinational capture decision and one buffer write per beat in the back end.
// A two-entry queue sits between classifier and capture logic; the result register
// holds while out_stall is high, and in_stall rises once the queue is full.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no beat is in flight. Indexes beyond the register
// list are ignored.
// Reset loads the default configuration, empties the capture, clears any pending
// frame and selects the first buffer for capture. Buffer memory needs no clearing:
// only entries written for the committed frame are ever read back.
module sync_delimited_pulse_frame_capture_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [sdpfc_pkg::DUR_W-1:0]     duration,
	input  logic [sdpfc_pkg::LEN_W-1:0]     read_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            frame_pending,
	output logic [sdpfc_pkg::LEN_W-1:0]     frame_length,
	output logic [sdpfc_pkg::DUR_W-1:0]     read_data,
	output logic                            frame_committed,
	output logic                            frame_dropped,
	output logic [sdpfc_pkg::LEN_W-1:0]     capture_length,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sdpfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdpfc_pkg::DUR_W-1:0]     cfg_data
);

	sdpfc_pkg::cfg_t    cfg_q;
	sdpfc_pkg::item_t   front_item;
	sdpfc_pkg::item_t   head_item;
	sdpfc_pkg::result_t res;
	logic               push;
	logic               pop;
	logic               queue_full;
	logic               head_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_min         <= sdpfc_pkg::SYNC_MIN_RST;
			cfg_q.sync_max         <= sdpfc_pkg::SYNC_MAX_RST;
			cfg_q.glitch_limit     <= sdpfc_pkg::GLITCH_LIMIT_RST;
			cfg_q.sync_cap         <= sdpfc_pkg::SYNC_CAP_RST;
			cfg_q.sync_fallback    <= sdpfc_pkg::SYNC_FALLBACK_RST;
			cfg_q.min_frame_length <= sdpfc_pkg::MIN_FRAME_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (sdpfc_pkg::cfg_idx_t'(cfg_index))
				sdpfc_pkg::CFG_SYNC_MIN:      cfg_q.sync_min      <= cfg_data;
				sdpfc_pkg::CFG_SYNC_MAX:      cfg_q.sync_max      <= cfg_data;
				sdpfc_pkg::CFG_GLITCH_LIMIT:  cfg_q.glitch_limit  <= cfg_data;
				sdpfc_pkg::CFG_SYNC_CAP:      cfg_q.sync_cap      <= cfg_data;
				sdpfc_pkg::CFG_SYNC_FALLBACK: cfg_q.sync_fallback <= cfg_data;
				sdpfc_pkg::CFG_MIN_FRAME_LEN: begin
					cfg_q.min_frame_length <= cfg_data[sdpfc_pkg::LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sdpfc_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.duration   (duration),
		.read_index (read_index),
		.cfg        (cfg_q),
		.queue_full (queue_full),
		.push       (push),
		.item       (front_item)
	);

	sdpfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (front_item),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	sdpfc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.it               (head_item),
		.min_frame_length (cfg_q.min_frame_length),
		.pop              (pop),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.res              (res),
		.read_data        (read_data)
	);

	assign frame_pending   = res.frame_pending;
	assign frame_length    = res.frame_length;
	assign frame_committed = res.frame_committed;
	assign frame_dropped   = res.frame_dropped;
	assign capture_length  = res.capture_length;

endmodule

// ===== rtl/core/sdpfc_checker.sv =====
// Port-level checker for the pulse frame capture block, bound to the top level.
module sdpfc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        frame_pending,
	input logic [sdpfc_pkg::LEN_W-1:0] frame_length,
	input logic [sdpfc_pkg::DUR_W-1:0] read_data,
	input logic                        frame_committed,
	input logic                        frame_dropped,
	input logic [sdpfc_pkg::LEN_W-1:0] capture_length
);

	a_commit_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_committed && frame_dropped))
		else $error("beat both committed and dropped a frame");

	a_pending_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_pending == (frame_length != '0)))
		else $error("pending flag disagrees with frame length");

	a_commit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_committed) |->
		(frame_pending && (capture_length == 9'd2 || capture_length == 9'd0)))
		else $error("commit left capture in an unexpected state");

	a_capture_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (capture_length != 9'd1))
		else $error("capture holds a single entry");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_data)
		&& $stable(capture_length)))
		else $error("stalled result beat changed");

endmodule

bind sync_delimited_pulse_frame_capture_top sdpfc_checker u_sdpfc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.frame_pending   (frame_pending),
	.frame_length    (frame_length),
	.read_data       (read_data),
	.frame_committed (frame_committed),
	.frame_dropped   (frame_dropped),
	.capture_length  (capture_length)
);
